// ===== hdl/ble_pkg.sv =====
// Shared types and constants of the bounded list engine.
`default_nettype none

package ble_pkg;

	// Command codes carried by the cmd field of a request.
	typedef enum logic [2:0] {
		CMD_PUSH   = 3'd0,
		CMD_POP    = 3'd1,
		CMD_FIND   = 3'd2,
		CMD_COUNT  = 3'd3,
		CMD_MINMAX = 3'd4,
		CMD_SORT   = 3'd5
	} cmd_t;

	// Result status codes.
	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2
	} status_t;

	// Source of the word written into the entry store.
	typedef enum logic {
		WR_VALUE = 1'b0,
		WR_CUR   = 1'b1
	} wr_src_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    start;     // request accepted: latch it and clear the result
		logic    empty;     // list holds no entry at accept time
		logic    full;      // push refused
		logic    rd_en;     // read the store at rd_addr
		logic    wr_en;     // write the store at wr_addr
		wr_src_t wr_src;
		logic    scan;      // fold the read word into the pop/find/count/minmax result
		logic    sort_ld;   // load the pivot word of a sort row
		logic    sort_cmp;  // compare the read word with the pivot, swap when out of order
		logic    load_out;  // move the finished result into the output register
	} dp_cmd_t;

	// Configuration port.
	localparam int unsigned PADDR_W      = 3;
	localparam logic        REG_CAPACITY = 1'b0;
	localparam logic [6:0]  CAPACITY_RST = 7'd64;

endpackage

`default_nettype wire

// ===== hdl/bounded_list_engine.sv =====
// Top level of the bounded list engine: configuration register, controller and datapath.
//
//  Channel    Handshake             Payload
//  request    req_valid/req_ready   cmd, value, ascending
//  response   rsp_valid/rsp_ready   status, found, position, match_count,
//                                   popped, max_value, min_value, length
//  config     APB (psel/penable)    capacity at byte address 0
//
// Per request, n being the fill at accept time: push, unused codes and any command on an
// empty list go straight to the result; pop reads the tail word; find, count and min/max
// read all n words, one stored word per cycle; sort, for n >= 2, does one compare per
// cycle plus a load and a write-back per row, with one read and one write store port.
// A new request is taken once the previous result sits in the response register; a later
// result holds until rsp_ready frees that register. Reset clears fill and sequencer and sets capacity to 64.
`default_nettype none

module bounded_list_engine #(
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// request channel
	input  wire logic                              req_valid,
	output logic                                   req_ready,
	input  wire logic [2:0]                        cmd,
	input  wire logic signed [31:0]                value,
	input  wire logic                              ascending,
	// response channel
	output logic                                   rsp_valid,
	input  wire logic                              rsp_ready,
	output logic [1:0]                             status,
	output logic                                   found,
	output logic [5:0]                             position,
	output logic [6:0]                             match_count,
	output logic signed [31:0]                     popped,
	output logic signed [31:0]                     max_value,
	output logic signed [31:0]                     min_value,
	output logic [6:0]                             length,
	// configuration port
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [ble_pkg::PADDR_W-1:0]       paddr,
	input  wire logic [31:0]                       pwdata,
	output logic [31:0]                            prdata,
	output logic                                   pready
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned FW = $clog2(DEPTH+1);

	logic [6:0]          capacity_q;
	logic                cfg_wr;
	logic                cap_sel;
	ble_pkg::dp_cmd_t    ctl;
	logic                swap;
	logic [AW-1:0]       rd_addr;
	logic [AW-1:0]       wr_addr;
	logic [FW-1:0]       fill;

	// Word index is paddr above the byte offset; only index 0 exists.
	assign cap_sel = (paddr[ble_pkg::PADDR_W-1:2] == ble_pkg::REG_CAPACITY);
	assign cfg_wr  = psel && penable && pwrite && cap_sel;
	assign pready  = 1'b1;
	assign prdata  = cap_sel ? {25'd0, capacity_q} : 32'd0;

	// Capacity may sit above DEPTH or at zero; the controller clips against both.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= ble_pkg::CAPACITY_RST;
		end else if (cfg_wr) begin
			capacity_q <= pwdata[6:0];
		end
	end

	ble_ctrl #(
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.cmd       (cmd),
		.capacity  (capacity_q),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.swap      (swap),
		.ctl       (ctl),
		.rd_addr   (rd_addr),
		.wr_addr   (wr_addr),
		.fill      (fill)
	);

	ble_dp #(
		.DEPTH (DEPTH)
	) u_dp (
		.clk         (clk),
		.ctl         (ctl),
		.rd_addr     (rd_addr),
		.wr_addr     (wr_addr),
		.fill        (fill),
		.cmd         (cmd),
		.value       (value),
		.ascending   (ascending),
		.swap        (swap),
		.status      (status),
		.found       (found),
		.position    (position),
		.match_count (match_count),
		.popped      (popped),
		.max_value   (max_value),
		.min_value   (min_value),
		.length      (length)
	);

	// The fill never runs past the store.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill <= FW'(DEPTH))
		else $error("fill count exceeds store depth");

	// The fill moves only on an accepted request.
	a_fill_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(req_valid && req_ready) |=> $stable(fill))
		else $error("fill count changed without a request");

	// The store is never read and written at one address in the same cycle.
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.rd_en && ctl.wr_en && rd_addr == wr_addr))
		else $error("entry store read and write collide");

	// An empty status always comes with an empty list.
	a_empty_len: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ble_pkg::STAT_EMPTY |-> length == 7'd0)
		else $error("empty status with nonzero length");

endmodule

`default_nettype wire

// ===== hdl/ble_dp.sv =====
// Datapath of the bounded list engine: entry store, result registers, sort pivot.
`default_nettype none

module ble_dp #(
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                         clk,
	input  wire ble_pkg::dp_cmd_t             ctl,
	input  wire logic [$clog2(DEPTH)-1:0]     rd_addr,
	input  wire logic [$clog2(DEPTH)-1:0]     wr_addr,
	input  wire logic [$clog2(DEPTH+1)-1:0]   fill,
	input  wire logic [2:0]                   cmd,
	input  wire logic signed [31:0]           value,
	input  wire logic                         ascending,
	output logic                              swap,
	output logic [1:0]                        status,
	output logic                              found,
	output logic [5:0]                        position,
	output logic [6:0]                        match_count,
	output logic signed [31:0]                popped,
	output logic signed [31:0]                max_value,
	output logic signed [31:0]                min_value,
	output logic [6:0]                        length
);

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned FW = $clog2(DEPTH+1);

	logic [31:0]        mem_q [DEPTH];
	logic [31:0]        rd_data_s1;
	logic [AW-1:0]      ra_s1;
	logic [31:0]        wr_data;

	ble_pkg::cmd_t      cmd_q;
	logic [31:0]        val_q;
	logic               asc_q;
	logic [31:0]        cur_q;

	ble_pkg::status_t   status_q;
	logic               found_q;
	logic [5:0]         pos_q;
	logic [FW-1:0]      cnt_q;
	logic [31:0]        popped_q;
	logic [31:0]        mx_q;
	logic [31:0]        mn_q;

	ble_pkg::status_t   status_o_q;
	logic               found_o_q;
	logic [5:0]         pos_o_q;
	logic [6:0]         cnt_o_q;
	logic [31:0]        popped_o_q;
	logic [31:0]        mx_o_q;
	logic [31:0]        mn_o_q;
	logic [6:0]         len_o_q;

	always_comb begin
		unique case (ctl.wr_src)
			ble_pkg::WR_VALUE: wr_data = value;
			ble_pkg::WR_CUR:   wr_data = cur_q;
			default:           wr_data = cur_q;
		endcase
	end

	// Single write port, single registered read port.
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data_s1 <= mem_q[rd_addr];
			ra_s1      <= rd_addr;
		end
	end

	always_comb begin
		if (asc_q) begin
			swap = $signed(cur_q) > $signed(rd_data_s1);
		end else begin
			swap = $signed(cur_q) < $signed(rd_data_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			cmd_q    <= ble_pkg::cmd_t'(cmd);
			val_q    <= value;
			asc_q    <= ascending;
			found_q  <= 1'b0;
			pos_q    <= '0;
			cnt_q    <= '0;
			popped_q <= '0;
			mx_q     <= '0;
			mn_q     <= '0;
			priority if (ctl.full) begin
				status_q <= ble_pkg::STAT_FULL;
			end else if (ctl.empty && (cmd == ble_pkg::CMD_POP || cmd == ble_pkg::CMD_MINMAX)) begin
				status_q <= ble_pkg::STAT_EMPTY;
			end else begin
				status_q <= ble_pkg::STAT_OK;
			end
		end else if (ctl.scan) begin
			unique case (cmd_q)
				ble_pkg::CMD_POP: begin
					popped_q <= rd_data_s1;
				end
				ble_pkg::CMD_FIND: begin
					if (!found_q && rd_data_s1 == val_q) begin
						found_q <= 1'b1;
						pos_q   <= 6'(ra_s1);
					end
				end
				ble_pkg::CMD_COUNT: begin
					if (rd_data_s1 == val_q) begin
						cnt_q <= cnt_q + FW'(1);
					end
				end
				ble_pkg::CMD_MINMAX: begin
					if (ra_s1 == '0) begin
						mx_q <= rd_data_s1;
						mn_q <= rd_data_s1;
					end else begin
						if ($signed(rd_data_s1) > $signed(mx_q)) begin
							mx_q <= rd_data_s1;
						end
						if ($signed(rd_data_s1) < $signed(mn_q)) begin
							mn_q <= rd_data_s1;
						end
					end
				end
				default: begin
				end
			endcase
		end

		// Pivot: the word that ends up at the row's head.
		if (ctl.sort_ld) begin
			cur_q <= rd_data_s1;
		end else if (ctl.sort_cmp && swap) begin
			cur_q <= rd_data_s1;
		end

		if (ctl.load_out) begin
			status_o_q <= status_q;
			found_o_q  <= found_q;
			pos_o_q    <= pos_q;
			cnt_o_q    <= 7'(cnt_q);
			popped_o_q <= popped_q;
			mx_o_q     <= mx_q;
			mn_o_q     <= mn_q;
			len_o_q    <= 7'(fill);
		end
	end

	assign status      = status_o_q;
	assign found       = found_o_q;
	assign position    = pos_o_q;
	assign match_count = cnt_o_q;
	assign popped      = popped_o_q;
	assign max_value   = mx_o_q;
	assign min_value   = mn_o_q;
	assign length      = len_o_q;

endmodule

`default_nettype wire

// ===== hdl/ble_ctrl.sv =====
// Controller of the bounded list engine: sequencing, fill count, handshakes.
`default_nettype none

module ble_ctrl #(
	parameter int unsigned DEPTH = 64
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         req_valid,
	output logic                              req_ready,
	input  wire logic [2:0]                   cmd,
	input  wire logic [6:0]                   capacity,
	output logic                              rsp_valid,
	input  wire logic                         rsp_ready,
	input  wire logic                         swap,
	output ble_pkg::dp_cmd_t                  ctl,
	output logic [$clog2(DEPTH)-1:0]          rd_addr,
	output logic [$clog2(DEPTH)-1:0]          wr_addr,
	output logic [$clog2(DEPTH+1)-1:0]        fill
);

	localparam int unsigned AW  = $clog2(DEPTH);
	localparam int unsigned FW  = $clog2(DEPTH+1);
	localparam int unsigned FW1 = FW + 1;
	localparam int unsigned CW  = (FW > 7) ? FW : 7;

	typedef enum logic [5:0] {
		ST_IDLE      = 6'b000001,
		ST_SCAN      = 6'b000010,
		ST_SORT_LD   = 6'b000100,
		ST_SORT_SCAN = 6'b001000,
		ST_SORT_WB   = 6'b010000,
		ST_RESULT    = 6'b100000
	} state_t;

	state_t         state_q, state_d;
	logic [FW-1:0]  fill_q, fill_d;
	logic [FW-1:0]  j_q, j_d;
	logic [AW-1:0]  i_q, i_d;
	logic           rsp_valid_q, rsp_valid_d;
	logic           accept;
	logic           is_empty;
	logic           has_room;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign is_empty  = (fill_q == '0);
	assign has_room  = (CW'(fill_q) < CW'(capacity)) && (fill_q != FW'(DEPTH));
	assign fill      = fill_q;
	assign rsp_valid = rsp_valid_q;

	always_comb begin
		state_d     = state_q;
		fill_d      = fill_q;
		j_d         = j_q;
		i_d         = i_q;
		rsp_valid_d = rsp_valid_q && !rsp_ready;
		rd_addr     = '0;
		wr_addr     = '0;
		ctl         = '0;
		ctl.wr_src  = ble_pkg::WR_CUR;

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					ctl.start = 1'b1;
					ctl.empty = is_empty;
					state_d   = ST_RESULT;
					unique case (cmd)
						ble_pkg::CMD_PUSH: begin
							ctl.full   = !has_room;
							ctl.wr_en  = has_room;
							ctl.wr_src = ble_pkg::WR_VALUE;
							wr_addr    = AW'(fill_q);
							if (has_room) begin
								fill_d = fill_q + FW'(1);
							end
						end
						ble_pkg::CMD_POP: begin
							// Read the tail; j past the new fill ends the scan after one word.
							if (!is_empty) begin
								ctl.rd_en = 1'b1;
								rd_addr   = AW'(fill_q - FW'(1));
								j_d       = fill_q;
								fill_d    = fill_q - FW'(1);
								state_d   = ST_SCAN;
							end
						end
						ble_pkg::CMD_FIND, ble_pkg::CMD_COUNT, ble_pkg::CMD_MINMAX: begin
							if (!is_empty) begin
								ctl.rd_en = 1'b1;
								rd_addr   = '0;
								j_d       = FW'(1);
								state_d   = ST_SCAN;
							end
						end
						ble_pkg::CMD_SORT: begin
							if (fill_q > FW'(1)) begin
								ctl.rd_en = 1'b1;
								rd_addr   = '0;
								i_d       = '0;
								state_d   = ST_SORT_LD;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_SCAN: begin
				ctl.scan = 1'b1;
				if (j_q < fill_q) begin
					ctl.rd_en = 1'b1;
					rd_addr   = AW'(j_q);
					j_d       = j_q + FW'(1);
				end else begin
					state_d = ST_RESULT;
				end
			end
			ST_SORT_LD: begin
				ctl.sort_ld = 1'b1;
				ctl.rd_en   = 1'b1;
				rd_addr     = i_q + AW'(1);
				j_d         = FW'(i_q) + FW'(2);
				state_d     = ST_SORT_SCAN;
			end
			ST_SORT_SCAN: begin
				// Swap: old pivot goes to the word just read, that word becomes pivot.
				ctl.sort_cmp = 1'b1;
				ctl.wr_en    = swap;
				wr_addr      = AW'(j_q - FW'(1));
				if (j_q < fill_q) begin
					ctl.rd_en = 1'b1;
					rd_addr   = AW'(j_q);
					j_d       = j_q + FW'(1);
				end else begin
					state_d = ST_SORT_WB;
				end
			end
			ST_SORT_WB: begin
				ctl.wr_en = 1'b1;
				wr_addr   = i_q;
				if (FW1'(i_q) + FW1'(2) < FW1'(fill_q)) begin
					ctl.rd_en = 1'b1;
					rd_addr   = i_q + AW'(1);
					i_d       = i_q + AW'(1);
					state_d   = ST_SORT_LD;
				end else begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (!rsp_valid_q || rsp_ready) begin
					ctl.load_out = 1'b1;
					rsp_valid_d  = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			j_q         <= '0;
			i_q         <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			fill_q      <= fill_d;
			j_q         <= j_d;
			i_q         <= i_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

endmodule

`default_nettype wire
